>>> design/mcpc_pkg.sv
// package for the marker cluster position classifier
// types shared by the cell row and the top level; no dependencies
package mcpc_pkg;

  localparam int unsigned CoordW = 14;
  localparam int unsigned CfgW   = 12;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              last_point;
  } in_req_t;

  typedef struct packed {
    logic       can_found;
    logic [1:0] position;
    logic [5:0] can_groups;
    logic       overflow;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEED,
    ST_SCAN,
    ST_TALLY,
    ST_CLASS,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    POS_LEFT   = 2'd0,
    POS_CENTRE = 2'd1,
    POS_RIGHT  = 2'd2
  } pos_t;

  localparam logic [0:0] REG_DIST  = 1'b0;
  localparam logic [0:0] REG_WIDTH = 1'b1;

endpackage

>>> design/marker_cluster_position_classifier.sv
// top level of the marker cluster position classifier
// row of mcpc_cell, grouping sequencer and classifier; uses mcpc_pkg
//
//  channel | ports                      | handshake
//  input   | in_start, in_busy, in_data | accepted when in_start and !in_busy
//  result  | out_valid, out_data        | one-cycle strobe, no backpressure
//  config  | cfg_we, cfg_index, cfg_data| written when cfg_we
//
// a point that is not last leaves in_busy low, so the block can take the next point without a wait;
// the frame closing item keeps in_busy high through the alignment rotation,
// (groups+1) scan passes over the row and the ST_CLASS and ST_DONE states,
// and the result strobe follows
// the points rotate through the cell row, one distance check per cycle against
// a held seed, the row length sets the scan time
// reset is synchronous; the result strobe cannot be stalled
module marker_cluster_position_classifier #(
  parameter int unsigned MAX_MARKERS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_start,
  output logic                      in_busy,
  input  mcpc_pkg::in_req_t         in_data,
  output logic                      out_valid,
  output mcpc_pkg::out_req_t        out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mcpc_pkg::CfgW-1:0] cfg_data
);
  import mcpc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_MARKERS + 1);

  logic [CfgW-1:0] dist_r, width_r;
  state_t st_r, st_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;   // stored points
  logic [CntW-1:0] rot_r, rot_nxt;   // rotation steps in a pass
  logic            ovf_r, ovf_nxt;
  logic [20:0]     sum_r, sum_nxt;
  logic [6:0]      tally_r, tally_nxt;
  logic [CoordW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [1:0]      mem_r, mem_nxt;     // members, saturating at 3
  logic [CoordW:0] gsum_r, gsum_nxt;   // seed plus one partner
  logic            seeded_r, seeded_nxt;
  logic [27:0]     lhs_r;
  logic [26:0]     base_r;
  out_req_t        res_r, res_nxt;
  logic            ov_r, ov_nxt;

  // cell row: head is cell 0, tail feeds back to head when rotating
  logic [CoordW-1:0] cx [MAX_MARKERS];
  logic [CoordW-1:0] cy [MAX_MARKERS];
  logic              cv [MAX_MARKERS];
  logic              cg [MAX_MARKERS];
  logic              shift, clr;
  logic [CoordW-1:0] hx_in, hy_in;
  logic              hv_in, hg_in;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_MARKERS; gi++) begin : g_row
      if (gi == 0) begin : g_head
        mcpc_cell u_cell (
          .clk, .rst_n, .shift_en(shift), .clr,
          .x_in(hx_in), .y_in(hy_in), .v_in(hv_in), .g_in(hg_in),
          .set_g(1'b0),
          .x_out(cx[gi]), .y_out(cy[gi]), .v_out(cv[gi]), .g_out(cg[gi])
        );
      end else begin : g_body
        mcpc_cell u_cell (
          .clk, .rst_n, .shift_en(shift), .clr,
          .x_in(cx[gi-1]), .y_in(cy[gi-1]), .v_in(cv[gi-1]), .g_in(cg[gi-1]),
          .set_g(1'b0),
          .x_out(cx[gi]), .y_out(cy[gi]), .v_out(cv[gi]), .g_out(cg[gi])
        );
      end
    end
  endgenerate

  // tail cell is the one under inspection; points enter at the head so the
  // tail holds the oldest point once the row has been rotated to order
  localparam int unsigned Tail = MAX_MARKERS - 1;

  // distance to seed, both squares are formed in the scan cycle itself
  logic [CoordW-1:0] dx, dy;
  logic [12+2-1:0]   lim4;
  logic [27:0]       lim_sq;
  assign dx = (cx[Tail] > sx_r) ? cx[Tail] - sx_r : sx_r - cx[Tail];
  assign dy = (cy[Tail] > sy_r) ? cy[Tail] - sy_r : sy_r - cy[Tail];
  assign lim4 = {dist_r, 2'b00};
  assign lim_sq = lim4 * lim4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r  <= CfgW'(150);
      width_r <= CfgW'(640);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIST:  dist_r  <= cfg_data;
        REG_WIDTH: width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      cnt_r <= '0; rot_r <= '0; ovf_r <= 1'b0; sum_r <= '0; tally_r <= '0;
      mem_r <= '0; seeded_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; rot_r <= rot_nxt; ovf_r <= ovf_nxt;
      sum_r <= sum_nxt; tally_r <= tally_nxt; mem_r <= mem_nxt;
      seeded_r <= seeded_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r <= sx_nxt; sy_r <= sy_nxt; gsum_r <= gsum_nxt; res_r <= res_nxt;
    lhs_r  <= 28'(sum_r) * 28'd100;
    base_r <= 27'(width_r) * 27'(tally_r);
  end

  // sequencer; during the scan each rotate step is a single close test. The
  // test uses the freshly computed squares combinationally for the tail cell:
  // dx*dx and dy*dy are 14x14 products, one level each, then an add/compare
  logic [28:0] dnow;
  logic        close;
  logic [35:0] b320, b480, lhs36;
  assign dnow  = 29'(28'(dx) * 28'(dx)) + 29'(28'(dy) * 28'(dy));
  assign close = (dnow < 29'(lim_sq));
  assign b320  = 36'(base_r) * 36'd320;
  assign b480  = 36'(base_r) * 36'd480;
  assign lhs36 = 36'(lhs_r);

  logic tail_live;
  assign tail_live = cv[Tail] && !cg[Tail];

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; rot_nxt = rot_r; ovf_nxt = ovf_r;
    sum_nxt = sum_r; tally_nxt = tally_r; sx_nxt = sx_r; sy_nxt = sy_r;
    mem_nxt = mem_r; gsum_nxt = gsum_r; seeded_nxt = seeded_r;
    res_nxt = res_r; ov_nxt = 1'b0;
    shift = 1'b0; clr = 1'b0;
    hx_in = cx[Tail]; hy_in = cy[Tail]; hv_in = cv[Tail]; hg_in = cg[Tail];
    in_busy = 1'b1;
    case (st_r)
      ST_LOAD: begin
        in_busy = 1'b0;
        if (in_start) begin
          if (cnt_r < CntW'(MAX_MARKERS)) begin
            // push the new point in at the head; older points move tailward
            shift = 1'b1;
            hx_in = in_data.point_x; hy_in = in_data.point_y;
            hv_in = 1'b1; hg_in = 1'b0;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_point) begin
            // align the oldest point to the tail
            rot_nxt = CntW'(MAX_MARKERS) - ((cnt_r < CntW'(MAX_MARKERS)) ?
                      cnt_r + 1'b1 : cnt_r);
            st_nxt = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        // rotate so the oldest point sits at the tail, then look for a seed
        if (rot_r != '0) begin
          shift = 1'b1; rot_nxt = rot_r - 1'b1;
        end else if (seeded_r) begin
          st_nxt = ST_TALLY;
        end else begin
          rot_nxt = CntW'(MAX_MARKERS);
          st_nxt = ST_SCAN;
          seeded_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        // one full rotation; the first live point becomes the seed, later
        // live points close to it join the group
        shift = 1'b1;
        rot_nxt = rot_r - 1'b1;
        if (tail_live) begin
          if (!seeded_r) begin
            seeded_nxt = 1'b1; hg_in = 1'b1;
            sx_nxt = cx[Tail]; sy_nxt = cy[Tail];
            mem_nxt = 2'd1; gsum_nxt = {1'b0, cx[Tail]} << 1;
          end else if (close) begin
            hg_in = 1'b1;
            if (mem_r != 2'd3) mem_nxt = mem_r + 1'b1;
            gsum_nxt = (CoordW+1)'(gsum_r >> 1) + (CoordW+1)'(cx[Tail]);
          end
        end
        if (rot_r == CntW'(1)) st_nxt = ST_TALLY;
      end
      ST_TALLY: begin
        if (seeded_r) begin
          if (mem_r == 2'd1 || mem_r == 2'd2) begin
            sum_nxt = sum_r + 21'(gsum_r);
            tally_nxt = tally_r + 1'b1;
          end
          seeded_nxt = 1'b0;
          rot_nxt = CntW'(MAX_MARKERS);
          st_nxt = ST_SCAN;
        end else begin
          st_nxt = ST_CLASS;  // a full pass found no seed
        end
      end
      ST_CLASS: begin
        st_nxt = ST_DONE;    // lets lhs and base settle in their registers
      end
      ST_DONE: begin
        res_nxt.can_found  = (tally_r != '0);
        res_nxt.can_groups = (tally_r > 7'd63) ? 6'd63 : tally_r[5:0];
        res_nxt.overflow   = ovf_r;
        if (tally_r == '0)      res_nxt.position = POS_LEFT;
        else if (lhs36 <= b320) res_nxt.position = POS_LEFT;
        else if (lhs36 <= b480) res_nxt.position = POS_CENTRE;
        else                    res_nxt.position = POS_RIGHT;
        ov_nxt = 1'b1;
        clr = 1'b1;
        cnt_nxt = '0; ovf_nxt = 1'b0; sum_nxt = '0; tally_nxt = '0;
        st_nxt = ST_LOAD;
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  // the seed was stored with gsum = 2x; a partner gives x1 + x2
  assign out_valid = ov_r;
  assign out_data  = res_r;
endmodule

>>> design/mcpc_cell.sv
// one storage cell of the marker row: holds a point and its grouped flag
// shifts its point to the next cell every rotate cycle; uses mcpc_pkg
module mcpc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic                          clr,
  input  logic [mcpc_pkg::CoordW-1:0]   x_in,
  input  logic [mcpc_pkg::CoordW-1:0]   y_in,
  input  logic                          v_in,
  input  logic                          g_in,
  input  logic                          set_g,
  output logic [mcpc_pkg::CoordW-1:0]   x_out,
  output logic [mcpc_pkg::CoordW-1:0]   y_out,
  output logic                          v_out,
  output logic                          g_out
);
  import mcpc_pkg::*;

  logic [CoordW-1:0] x_r, y_r;
  logic              v_r, g_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      x_r <= x_in;
      y_r <= y_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      v_r <= 1'b0;
      g_r <= 1'b0;
    end else if (shift_en) begin
      v_r <= v_in;
      g_r <= g_in;
    end else if (set_g) begin
      g_r <= 1'b1;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign v_out = v_r;
  assign g_out = g_r;
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for marker_cluster_position_classifier: frames of marker points
// are checked against a frame grouping predictor; uses mcpc_pkg and the rtl
module tb_top;
  import mcpc_pkg::*;

  localparam int unsigned MaxMarkers = 32;
  localparam int unsigned FrameLat = MaxMarkers * (MaxMarkers + 1) + 40;
  localparam int unsigned CycleLimit = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_start = 1'b0;
  logic in_busy;
  in_req_t in_data = '0;
  logic out_valid;
  out_req_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CfgW-1:0] cfg_data = '0;

  marker_cluster_position_classifier #(.MAX_MARKERS(MaxMarkers)) dut (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the block state
  logic [CfgW-1:0] grp_limit = 12'd150;
  logic [CfgW-1:0] frm_width = 12'd640;
  logic [CoordW-1:0] pt_x [MaxMarkers];
  logic [CoordW-1:0] pt_y [MaxMarkers];
  int unsigned pt_count = 0;
  bit pt_dropped = 1'b0;

  out_req_t frame_results [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;

  // greedy grouping of the collected frame, then can position classification
  function automatic out_req_t classify_frame();
    bit taken [MaxMarkers];
    longint unsigned lim_sq, x_sum, lhs, base, dx, dy;
    int unsigned tally, members;
    out_req_t r;
    lim_sq = longint'(grp_limit) * 4 * longint'(grp_limit) * 4;
    x_sum = 0;
    tally = 0;
    foreach (taken[k]) taken[k] = 1'b0;
    for (int i = 0; i < pt_count; i++) begin
      if (taken[i]) continue;
      taken[i] = 1'b1;
      members = 1;
      lhs = pt_x[i];
      for (int j = 0; j < pt_count; j++) begin
        dx = (pt_x[i] > pt_x[j]) ? pt_x[i] - pt_x[j] : pt_x[j] - pt_x[i];
        dy = (pt_y[i] > pt_y[j]) ? pt_y[i] - pt_y[j] : pt_y[j] - pt_y[i];
        if (!taken[j] && dx * dx + dy * dy < lim_sq) begin
          taken[j] = 1'b1;
          members++;
          lhs += pt_x[j];
        end
      end
      // a lone point counts twice so the sum stays in eighth pixels
      if (members == 1) begin
        x_sum += 2 * lhs; tally++;
      end else if (members == 2) begin
        x_sum += lhs; tally++;
      end
    end
    r = '0;
    r.can_found = (tally > 0);
    r.position = POS_LEFT;
    if (tally > 0) begin
      lhs = x_sum * 100;
      base = longint'(frm_width) * tally;
      if (lhs <= 320 * base) r.position = POS_LEFT;
      else if (lhs <= 480 * base) r.position = POS_CENTRE;
      else r.position = POS_RIGHT;
    end
    r.can_groups = (tally > 63) ? 6'd63 : tally[5:0];
    r.overflow = pt_dropped;
    return r;
  endfunction

  // apply one accepted request to the predictor
  task automatic absorb_point(input in_req_t p);
    if (pt_count < MaxMarkers) begin
      pt_x[pt_count] = p.point_x;
      pt_y[pt_count] = p.point_y;
      pt_count++;
    end else begin
      pt_dropped = 1'b1;
    end
    if (p.last_point) begin
      frame_results = {frame_results, classify_frame()};
      pt_count = 0;
      pt_dropped = 1'b0;
    end
  endtask

  // result checker, sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    out_req_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (frame_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        want = frame_results.pop_front();
        if (out_data.can_found !== want.can_found)
          $display("%0t: can_found exp %0d got %0d", $time, want.can_found,
                   out_data.can_found);
        if (out_data.position !== want.position)
          $display("%0t: position exp %0d got %0d", $time, want.position,
                   out_data.position);
        if (out_data.can_groups !== want.can_groups)
          $display("%0t: can_groups exp %0d got %0d", $time, want.can_groups,
                   out_data.can_groups);
        if (out_data.overflow !== want.overflow)
          $display("%0t: overflow exp %0d got %0d", $time, want.overflow,
                   out_data.overflow);
        if (out_data !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // wait for the block to drain, then write one register
  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    in_start <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (FrameLat) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DIST) grp_limit = val;
    else frm_width = val;
  endtask

  // send one request; optional idle burst before it, start stays high after
  task automatic send_point(input in_req_t p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_start <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_busy) @(posedge clk);
    absorb_point(p);
  endtask

  function automatic in_req_t mk(input int x, input int y, input bit last);
    in_req_t p;
    p.point_x = CoordW'(x);
    p.point_y = CoordW'(y);
    p.last_point = last;
    return p;
  endfunction

  // directed rows; typed result only where obvious, else predictor
  typedef struct {
    in_req_t req;
    bit has_want;
    out_req_t want;
  } row_t;

  row_t rows [$];

  task automatic add_row(input in_req_t p, input bit hw, input out_req_t w);
    row_t r;
    r.req = p;
    r.has_want = hw;
    r.want = w;
    rows = {rows, r};
  endtask

  // a frame of clustered points: random centers, some pairs, some crowds
  task automatic random_frame(input int unsigned npts);
    int cx, cy;
    in_req_t p;
    for (int k = 0; k < npts; k++) begin
      if (k == 0 || $urandom_range(0, 2) == 0) begin
        cx = $urandom_range(0, 16380);
        cy = $urandom_range(0, 16380);
      end
      if ($urandom_range(0, 9) == 0)
        p = mk($urandom_range(0, 16383), $urandom_range(0, 16383), 1'b0);
      else
        p = mk((cx + $urandom_range(0, 800)) % 16384,
               (cy + $urandom_range(0, 800)) % 16384, 1'b0);
      p.last_point = (k == npts - 1);
      send_point(p);
    end
  endtask

  initial begin
    out_req_t w;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point at zero: one can, left
    w = '{can_found: 1'b1, position: POS_LEFT, can_groups: 6'd1, overflow: 1'b0};
    add_row(mk(0, 0, 1'b1), 1'b1, w);
    // single point at the far edge: right
    w.position = POS_RIGHT;
    add_row(mk(16383, 16383, 1'b1), 1'b1, w);
    // close pair, then a far lone point
    add_row(mk(1000, 1000, 1'b0), 1'b0, w);
    add_row(mk(1010, 1000, 1'b0), 1'b0, w);
    add_row(mk(9000, 200, 1'b1), 1'b0, w);
    // crowd of three: no can at all
    add_row(mk(5000, 5000, 1'b0), 1'b0, w);
    add_row(mk(5001, 5000, 1'b0), 1'b0, w);
    w = '{can_found: 1'b0, position: POS_LEFT, can_groups: 6'd0, overflow: 1'b0};
    add_row(mk(5000, 5001, 1'b1), 1'b1, w);
    // exact boundary for 40 percent of 640: x = 256 px = 1024 quarter px
    add_row(mk(1024, 0, 1'b1), 1'b0, w);
    add_row(mk(1025, 0, 1'b1), 1'b0, w);
    add_row(mk(1536, 0, 1'b1), 1'b0, w);
    add_row(mk(1537, 9999, 1'b1), 1'b0, w);
    add_row(mk(10922, 5461, 1'b1), 1'b0, w);
    foreach (rows[i]) begin
      send_point(rows[i].req);
      if (rows[i].has_want && frame_results[$] !== rows[i].want) begin
        $display("%0t: table row %0d exp %p got %p", $time, i, rows[i].want,
                 frame_results[$]);
        errors++;
      end
    end

    // overflow: 34 points, the last two dropped, the last one still closes the frame
    for (int k = 0; k < 34; k++)
      send_point(mk(k * 480, (k * 7919) % 16384, k == 33));

    // zero distance and zero width extremes
    write_reg(REG_DIST, 12'd0);
    write_reg(REG_WIDTH, 12'd0);
    send_point(mk(0, 0, 1'b0));
    send_point(mk(0, 0, 1'b1));
    send_point(mk(3, 7, 1'b1));
    random_frame(6);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_DIST, 12'd4095); write_reg(REG_WIDTH, 12'd4095); end
        1: begin write_reg(REG_DIST, 12'd1); write_reg(REG_WIDTH, 12'd1); end
        2: begin write_reg(REG_DIST, 12'd150); write_reg(REG_WIDTH, 12'd640); end
        default: begin
          write_reg(REG_DIST, CfgW'($urandom_range(1, 400)));
          write_reg(REG_WIDTH, CfgW'($urandom_range(1, 4095)));
        end
      endcase
      if (ph == 5) quiet = 1'b1;
      for (int f = 0; f < 9; f++) begin
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                         : $urandom_range(1, 6);
        random_frame(n);
        // sender holds off until the block has drained
        if (f == 3) begin
          in_start <= 1'b0;
          @(posedge clk);
          while (frame_results.size() != 0) @(posedge clk);
        end
      end
    end

    in_start <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (FrameLat) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
